@@ design/bmpc_pkg.sv @@
package bmpc_pkg;

    // result kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_LAST  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DISP_W   = 2'd0;
    localparam logic [1:0] CFG_DISP_H   = 2'd1;
    localparam logic [1:0] CFG_FILE_LEN = 2'd2;

    localparam logic [31:0] HDR_BYTES   = 32'd54;
    localparam logic [31:0] LAST_HDR_IX = 32'd53;

    typedef struct packed {
        logic [15:0] sig;
        logic [31:0] declared;
        logic [31:0] poff;
        logic [31:0] dib;
        logic [31:0] ws;
        logic [31:0] hs;
        logic [31:0] planes_depth;
        logic [31:0] compr;
    } t_hdr_fields;

    typedef struct packed {
        logic        ok;
        logic        top_down;
        logic [31:0] src_w;
        logic [31:0] src_h;
        logic [10:0] win_w;
        logic [10:0] win_h;
        logic [31:0] org_c;
        logic [31:0] org_r;
        logic [31:0] pitch;
    } t_hdr_res;

endpackage

@@ design/bmp24_crop_to_rgb565_unit.sv @@
// Streaming decoder for uncompressed 24-bit BMP files. Bytes of the file enter
// one per transfer, in file order; file_length must be set beforehand. The
// 54-byte header is captured and checked, bytes up to the pixel offset are
// skipped, and the padded rows (bottom-up or top-down) are walked. Each pixel of
// the centred window, clipped to the display size, leaves as one RGB565 result
// with its window column and row; the final pixel in stream order has kind 1.
// A failed check gives one error result (kind 2, other fields 0) and the rest of
// the file is consumed without results. After file_length bytes the decoder is
// ready for the next file. Throughput is one byte per clock, set by the pixel
// walker, while the results side accepts; the exception is the last header byte,
// after which the decoder takes no byte while the three-stage header checker
// (one 32x32 multiply) runs and its result is picked up.
module bmp24_crop_to_rgb565_unit
    import bmpc_pkg::*;
#(
    parameter int MAX_DISPLAY_WIDTH  = 1024,
    parameter int MAX_DISPLAY_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_pixel_color,
    output logic [9:0]  o_out_column,
    output logic [9:0]  o_out_row,
    output logic [10:0] o_image_width,
    output logic [10:0] o_image_height,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [10:0] r_disp_w;
    logic [10:0] r_disp_h;
    logic [31:0] r_file_len;

    assign o_cfg_ready = 1'b1;

    // config registers; unknown index is ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w   <= 11'd320;
            r_disp_h   <= 11'd240;
            r_file_len <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DISP_W:   r_disp_w   <= i_cfg_data[10:0];
                CFG_DISP_H:   r_disp_h   <= i_cfg_data[10:0];
                CFG_FILE_LEN: r_file_len <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: byte queue decoupling the source from the decoder
    logic       q_valid;
    logic [7:0] q_byte;
    logic       q_pop;

    bmpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_data_byte),
        .o_valid (q_valid),
        .o_byte  (q_byte),
        .i_pop   (q_pop)
    );

    // back: header capture/check, row walker, output register
    bmpc_back #(
        .MAX_DISPLAY_WIDTH  (MAX_DISPLAY_WIDTH),
        .MAX_DISPLAY_HEIGHT (MAX_DISPLAY_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_byte       (q_byte),
        .o_q_pop        (q_pop),
        .i_disp_w       (r_disp_w),
        .i_disp_h       (r_disp_h),
        .i_file_len     (r_file_len),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_pixel_color  (o_pixel_color),
        .o_out_column   (o_out_column),
        .o_out_row      (o_out_row),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height)
    );

endmodule

@@ design/bmpc_front.sv @@
module bmpc_front
    import bmpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_pop
);

    // two-entry byte queue
    logic [7:0] r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_byte  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

@@ design/bmpc_hdr.sv @@
module bmpc_hdr
    import bmpc_pkg::*;
#(
    parameter int MAX_DISPLAY_WIDTH  = 1024,
    parameter int MAX_DISPLAY_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_hdr_fields i_fields,
    input  logic [10:0] i_disp_w,
    input  logic [10:0] i_disp_h,
    input  logic [31:0] i_file_len,
    output logic        o_done,
    output t_hdr_res    o_res
);

    localparam logic [16:0] MaxW = 17'(MAX_DISPLAY_WIDTH);
    localparam logic [16:0] MaxH = 17'(MAX_DISPLAY_HEIGHT);

    // stage 1: field checks, padded row size
    logic        s1_ok;
    logic        s1_top;
    logic [31:0] s1_srch;
    logic [33:0] s1_ws3;
    logic [33:0] s1_row;
    logic [16:0] dw17;
    logic [16:0] dh17;

    always_comb begin
        s1_top  = i_fields.hs[31];
        s1_srch = s1_top ? (32'd0 - i_fields.hs) : i_fields.hs;
        s1_ws3  = {2'b00, i_fields.ws} + {1'b0, i_fields.ws, 1'b0};
        s1_row  = (s1_ws3 + 34'd3) & ~34'd3;
        s1_ok   = (i_fields.sig == 16'h4D42)
               && (i_fields.declared >= HDR_BYTES)
               && (i_fields.declared <= i_file_len)
               && (i_fields.dib >= 32'd40)
               && (i_fields.ws != 32'd0) && !i_fields.ws[31]
               && (i_fields.hs != 32'd0) && (i_fields.hs != 32'h8000_0000)
               && (i_fields.planes_depth == 32'h0018_0001)
               && (i_fields.compr == 32'd0)
               && ({1'b0, i_fields.poff} >= (33'd14 + {1'b0, i_fields.dib}))
               && (i_fields.poff <= i_file_len)
               && (s1_row[33:32] == 2'b00);
        dw17 = ({6'd0, i_disp_w} < MaxW) ? {6'd0, i_disp_w} : MaxW;
        dh17 = ({6'd0, i_disp_h} < MaxH) ? {6'd0, i_disp_h} : MaxH;
    end

    logic        r_ok1;
    logic        r_top;
    logic [31:0] r_srcw;
    logic [31:0] r_srch;
    logic [31:0] r_row;
    logic [10:0] r_dw;
    logic [10:0] r_dh;
    logic [63:0] r_prod;
    logic [10:0] r_ww;
    logic [10:0] r_wh;
    logic [2:0]  r_stg;
    logic        r_done;
    t_hdr_res    r_res;

    logic [64:0] s3_end;
    always_comb begin
        s3_end = {33'd0, r_prod[31:0]} + {1'b0, r_prod[63:32], 32'd0}
               + {33'd0, i_fields.poff};
    end

    always_ff @(posedge i_clk) begin
        // stage 1
        r_ok1  <= s1_ok;
        r_top  <= s1_top;
        r_srcw <= i_fields.ws;
        r_srch <= s1_srch;
        r_row  <= s1_row[31:0];
        r_dw   <= dw17[10:0];
        r_dh   <= dh17[10:0];
        // stage 2: row size times height, window size
        r_prod <= r_row * r_srch;
        r_ww   <= (r_srcw < {21'd0, r_dw}) ? r_srcw[10:0] : r_dw;
        r_wh   <= (r_srch < {21'd0, r_dh}) ? r_srch[10:0] : r_dh;
        // stage 3: end of pixel data, window origin
        if (r_stg[1]) begin
            r_res.ok        <= r_ok1 && (r_dw != 11'd0) && (r_dh != 11'd0)
                            && (s3_end <= {33'd0, i_file_len})
                            && (s3_end <= {33'd0, i_fields.declared});
            r_res.top_down  <= r_top;
            r_res.src_w     <= r_srcw;
            r_res.src_h     <= r_srch;
            r_res.win_w     <= r_ww;
            r_res.win_h     <= r_wh;
            r_res.org_c     <= (r_srcw - {21'd0, r_ww}) >> 1;
            r_res.org_r     <= (r_srch - {21'd0, r_wh}) >> 1;
            r_res.pitch     <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_stg <= {r_stg[1:0], i_start};
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_stg[2]) begin
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

@@ design/bmpc_back.sv @@
module bmpc_back
    import bmpc_pkg::*;
#(
    parameter int MAX_DISPLAY_WIDTH  = 1024,
    parameter int MAX_DISPLAY_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  logic [7:0]  i_q_byte,
    output logic        o_q_pop,
    input  logic [10:0] i_disp_w,
    input  logic [10:0] i_disp_h,
    input  logic [31:0] i_file_len,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_pixel_color,
    output logic [9:0]  o_out_column,
    output logic [9:0]  o_out_row,
    output logic [10:0] o_image_width,
    output logic [10:0] o_image_height
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHECK,
        PH_SKIP,
        PH_PIXELS,
        PH_DRAIN
    } t_phase;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [31:0] r_count;
    t_hdr_fields r_fields;
    logic [32:0] r_row;
    logic [31:0] r_pos;
    logic [31:0] r_p;
    logic [1:0]  r_k;
    logic [15:0] r_partial;

    logic        r_o_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_color;
    logic [9:0]  r_col;
    logic [9:0]  r_orow;
    logic [10:0] r_iw;
    logic [10:0] r_ih;

    logic        hdr_start;
    logic        hdr_done;
    t_hdr_res    res;

    bmpc_hdr #(
        .MAX_DISPLAY_WIDTH  (MAX_DISPLAY_WIDTH),
        .MAX_DISPLAY_HEIGHT (MAX_DISPLAY_HEIGHT)
    ) u_hdr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (hdr_start),
        .i_fields   (r_fields),
        .i_disp_w   (i_disp_w),
        .i_disp_h   (i_disp_h),
        .i_file_len (i_file_len),
        .o_done     (hdr_done),
        .o_res      (res)
    );

    logic        out_free;
    logic        go;
    logic        chk_go;
    logic        step;
    logic        eof;
    logic [31:0] cnt1;
    logic        emit;
    logic [1:0]  e_kind;
    logic [15:0] e_color;
    logic [9:0]  e_col;
    logic [9:0]  e_row;
    logic [10:0] e_iw;
    logic [10:0] e_ih;
    logic [31:0] img;
    logic [31:0] orow;
    logic [31:0] ocol;
    logic        in_src;
    logic        in_win;
    logic        last;
    logic [32:0] pos1;
    logic        row_end;

    always_comb begin
        out_free = !r_o_valid || i_out_ready;
        go       = i_q_valid && out_free && (r_phase != PH_CHECK);
        chk_go   = (r_phase == PH_CHECK) && hdr_done && out_free;
        step     = go || chk_go;
        cnt1     = r_count + 32'd1;
        eof      = (cnt1 >= i_file_len);

        img    = res.top_down ? r_row[31:0] : (res.src_h - 32'd1 - r_row[31:0]);
        orow   = img - res.org_r;
        ocol   = r_p - res.org_c;
        in_src = (r_k == 2'd2) && (r_p < res.src_w) && (r_row < {1'b0, res.src_h});
        in_win = (img >= res.org_r) && (orow < {21'd0, res.win_h})
              && (r_p >= res.org_c) && (ocol < {21'd0, res.win_w});
        last   = (ocol == {21'd0, res.win_w - 11'd1})
              && (orow == (res.top_down ? {21'd0, res.win_h - 11'd1} : 32'd0));
        pos1    = {1'b0, r_pos} + 33'd1;
        row_end = (pos1 >= {1'b0, res.pitch});

        n_phase   = r_phase;
        hdr_start = 1'b0;
        emit      = 1'b0;
        e_kind    = KIND_ERROR;
        e_color   = 16'd0;
        e_col     = 10'd0;
        e_row     = 10'd0;
        e_iw      = 11'd0;
        e_ih      = 11'd0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_count == 32'd0 && i_file_len < HDR_BYTES) begin
                    emit    = 1'b1;
                    n_phase = PH_DRAIN;
                end else if (r_count == LAST_HDR_IX) begin
                    hdr_start = go;
                    n_phase   = PH_CHECK;
                    eof       = 1'b0;   // end of file resolved after the check
                end
            end
            PH_CHECK: begin
                eof = (r_count >= i_file_len);
                if (res.ok) begin
                    n_phase = (r_count >= r_fields.poff) ? PH_PIXELS : PH_SKIP;
                end else begin
                    emit    = 1'b1;
                    n_phase = PH_DRAIN;
                end
            end
            PH_SKIP: begin
                if (cnt1 >= r_fields.poff) begin
                    n_phase = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                if (in_src && in_win) begin
                    emit    = 1'b1;
                    e_kind  = last ? KIND_LAST : KIND_PIXEL;
                    e_color = {i_q_byte[7:3], r_partial[15:10], r_partial[7:3]};
                    e_col   = ocol[9:0];
                    e_row   = orow[9:0];
                    e_iw    = res.win_w;
                    e_ih    = res.win_h;
                    if (last) begin
                        n_phase = PH_DRAIN;
                    end
                end
            end
            PH_DRAIN: begin
            end
            default: begin
            end
        endcase
    end

    assign o_q_pop = go;

    // header byte capture
    always_ff @(posedge i_clk) begin
        if (go && r_phase == PH_HEADER) begin
            case (r_count[5:0])
                6'd0:  r_fields.sig[7:0]             <= i_q_byte;
                6'd1:  r_fields.sig[15:8]            <= i_q_byte;
                6'd2:  r_fields.declared[7:0]        <= i_q_byte;
                6'd3:  r_fields.declared[15:8]       <= i_q_byte;
                6'd4:  r_fields.declared[23:16]      <= i_q_byte;
                6'd5:  r_fields.declared[31:24]      <= i_q_byte;
                6'd10: r_fields.poff[7:0]            <= i_q_byte;
                6'd11: r_fields.poff[15:8]           <= i_q_byte;
                6'd12: r_fields.poff[23:16]          <= i_q_byte;
                6'd13: r_fields.poff[31:24]          <= i_q_byte;
                6'd14: r_fields.dib[7:0]             <= i_q_byte;
                6'd15: r_fields.dib[15:8]            <= i_q_byte;
                6'd16: r_fields.dib[23:16]           <= i_q_byte;
                6'd17: r_fields.dib[31:24]           <= i_q_byte;
                6'd18: r_fields.ws[7:0]              <= i_q_byte;
                6'd19: r_fields.ws[15:8]             <= i_q_byte;
                6'd20: r_fields.ws[23:16]            <= i_q_byte;
                6'd21: r_fields.ws[31:24]            <= i_q_byte;
                6'd22: r_fields.hs[7:0]              <= i_q_byte;
                6'd23: r_fields.hs[15:8]             <= i_q_byte;
                6'd24: r_fields.hs[23:16]            <= i_q_byte;
                6'd25: r_fields.hs[31:24]            <= i_q_byte;
                6'd26: r_fields.planes_depth[7:0]    <= i_q_byte;
                6'd27: r_fields.planes_depth[15:8]   <= i_q_byte;
                6'd28: r_fields.planes_depth[23:16]  <= i_q_byte;
                6'd29: r_fields.planes_depth[31:24]  <= i_q_byte;
                6'd30: r_fields.compr[7:0]           <= i_q_byte;
                6'd31: r_fields.compr[15:8]          <= i_q_byte;
                6'd32: r_fields.compr[23:16]         <= i_q_byte;
                6'd33: r_fields.compr[31:24]         <= i_q_byte;
                default: begin
                end
            endcase
        end
    end

    // payload of the output stage and partial pixel
    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_kind  <= e_kind;
            r_color <= e_color;
            r_col   <= e_col;
            r_orow  <= e_row;
            r_iw    <= e_iw;
            r_ih    <= e_ih;
        end
        if (go && r_phase == PH_PIXELS) begin
            if (r_k == 2'd0) begin
                r_partial[7:0] <= i_q_byte;
            end else if (r_k == 2'd1) begin
                r_partial[15:8] <= i_q_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_count   <= 32'd0;
            r_row     <= 33'd0;
            r_pos     <= 32'd0;
            r_p       <= 32'd0;
            r_k       <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (step && emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (step) begin
                if (eof) begin
                    r_phase <= PH_HEADER;
                    r_count <= 32'd0;
                    r_row   <= 33'd0;
                    r_pos   <= 32'd0;
                    r_p     <= 32'd0;
                    r_k     <= 2'd0;
                end else begin
                    r_phase <= n_phase;
                    if (go) begin
                        r_count <= cnt1;
                    end
                    if (go && r_phase == PH_PIXELS) begin
                        if (row_end) begin
                            r_pos <= 32'd0;
                            r_p   <= 32'd0;
                            r_k   <= 2'd0;
                            r_row <= r_row + 33'd1;
                        end else begin
                            r_pos <= pos1[31:0];
                            r_k   <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                            r_p   <= (r_k == 2'd2) ? r_p + 32'd1 : r_p;
                        end
                    end
                end
            end
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_kind;
    assign o_pixel_color  = r_color;
    assign o_out_column   = r_col;
    assign o_out_row      = r_orow;
    assign o_image_width  = r_iw;
    assign o_image_height = r_ih;

endmodule

@@ verif/bmp24_crop_to_rgb565_unit_test.sv @@
module bmp24_crop_to_rgb565_unit_test;
    import bmpc_pkg::*;

    // Inactivity limit, in cycles with no transfer on any channel. Covers the
    // register pause, the header check stall and long random stalls.
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_BYTES = 400;
    localparam int MAX_DW = 1024;
    localparam int MAX_DH = 1024;

    // Ways a test file can be built, including each deliberate format fault
    typedef enum {
        FC_OK, FC_SHORT, FC_BAD_SIG, FC_BAD_DEPTH, FC_COMPRESSED, FC_HEIGHT_MIN,
        FC_WIDTH_NEG, FC_TRUNCATED, FC_OFFSET_LOW, FC_DIB_SMALL, FC_BITFLIP
    } file_case_e;

    typedef enum logic [1:0] {ST_HEADER, ST_SKIP, ST_PIXELS, ST_DRAIN} dec_state_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] color;
        logic [9:0]  col;
        logic [9:0]  row;
        logic [10:0] iw;
        logic [10:0] ih;
    } t_px;

    typedef struct {
        int unsigned dw;
        int unsigned dh;
        int unsigned w;     // image width, or file length for short files
        int unsigned h;
        bit          td;
        file_case_e  fcase;
    } t_file_spec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_DISP_W;
    logic [31:0] i_cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [15:0] o_pixel_color;
    logic [9:0]  o_out_column;
    logic [9:0]  o_out_row;
    logic [10:0] o_image_width;
    logic [10:0] o_image_height;
    logic        o_cfg_ready;

    bmp24_crop_to_rgb565_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_pixel_color  (o_pixel_color),
        .o_out_column   (o_out_column),
        .o_out_row      (o_out_row),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Decoder mirror: registers, per-file state and the byte step
    // ------------------------------------------------------------------
    logic [10:0]  disp_w, disp_h;
    logic [31:0]  file_len;
    logic [31:0]  dec_cnt;
    dec_state_e   dec_state;
    logic [31:0]  hdr [8];
    logic [63:0]  row_len;
    logic [31:0]  org_c, org_r;
    logic [63:0]  src_row, row_pos;
    logic [15:0]  part_px;          // green high byte, blue low byte
    logic [31:0]  src_w, src_h, win_w, win_h;
    bit           top_down;

    t_px          pending_pixels [$];
    int           n_mismatch = 0;
    bit           typed_err = 1'b0;  // expected results typed in for this file
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           rnd_bytes = 0;
    int           file_no = 0;
    logic [7:0]   hb [54];
    logic [7:0]   file_bytes [$];

    function automatic void clear_file();
        dec_cnt = '0;
        dec_state = ST_HEADER;
        foreach (hdr[i]) hdr[i] = '0;
        row_len = '0;
        org_c = '0;
        org_r = '0;
        src_row = '0;
        row_pos = '0;
        part_px = '0;
        src_w = '0;
        src_h = '0;
        win_w = '0;
        win_h = '0;
        top_down = 1'b0;
    endfunction

    // Header fields are gathered little-endian; reserved bytes and the tail
    // of the info header beyond compression are not kept.
    function automatic void grab_header_byte(input logic [31:0] n, input logic [7:0] b);
        int          w;
        logic [31:0] base;
        if (n < 2) begin
            w = 0; base = 0;
        end else if (n < 6) begin
            w = 1; base = 2;
        end else if (n < 10 || n >= 34) begin
            return;
        end else begin
            w = 2 + (n - 10) / 4; base = 10 + 4 * (w - 2);
        end
        hdr[w] = hdr[w] | ({24'd0, b} << (8 * (n - base)));
    endfunction

    function automatic bit header_ok();
        logic [31:0] declared, poff, dib, ws, hs, dw, dh;
        logic [63:0] rowl, fend;
        declared = hdr[1];
        poff = hdr[2];
        dib = hdr[3];
        ws = hdr[4];
        hs = hdr[5];
        if (hdr[0] != 32'h4D42) return 1'b0;
        if (declared < 54 || declared > file_len || dib < 40) return 1'b0;
        if (ws == 0 || ws[31]) return 1'b0;
        if (hs == 0 || hs == 32'h8000_0000) return 1'b0;
        if (hdr[6][15:0] != 16'd1 || hdr[6][31:16] != 16'd24 || hdr[7] != 0) return 1'b0;
        if ({32'd0, poff} < 64'd14 + dib || poff > file_len) return 1'b0;
        top_down = hs[31];
        src_w = ws;
        src_h = top_down ? (32'd0 - hs) : hs;
        rowl = ({32'd0, src_w} * 3 + 3) & ~64'd3;
        if (rowl > 64'hFFFF_FFFF) return 1'b0;
        fend = {32'd0, poff} + rowl * {32'd0, src_h};
        if (fend > file_len || fend > declared) return 1'b0;
        dw = (disp_w < MAX_DW) ? disp_w : MAX_DW;
        dh = (disp_h < MAX_DH) ? disp_h : MAX_DH;
        if (dw == 0 || dh == 0) return 1'b0;
        win_w = (src_w < dw) ? src_w : dw;
        win_h = (src_h < dh) ? src_h : dh;
        org_c = (src_w - win_w) / 2;
        org_r = (src_h - win_h) / 2;
        row_len = rowl;
        return 1'b1;
    endfunction

    // One accepted byte; returns 1 when it yields a result.
    function automatic bit decode_byte(input logic [7:0] b, output t_px px);
        logic [31:0] n, lastrow;
        logic [63:0] p, k, img, orow, ocol;
        bit          got, bad, fin;
        n = dec_cnt;
        dec_cnt = n + 1;
        got = 1'b0;
        px = '0;
        if (dec_state == ST_HEADER) begin
            bad = 1'b0;
            if (n == 0 && file_len < 54) begin
                bad = 1'b1;
            end else begin
                grab_header_byte(n, b);
                if (n == 53) begin
                    if (header_ok()) dec_state = ST_SKIP;
                    else bad = 1'b1;
                end
            end
            if (bad) begin
                px.kind = KIND_ERROR;
                got = 1'b1;
                dec_state = ST_DRAIN;
            end
        end else if (dec_state == ST_PIXELS) begin
            p = row_pos / 3;
            k = row_pos % 3;
            if (k == 0) begin
                part_px[7:0] = b;
            end else if (k == 1) begin
                part_px[15:8] = b;
            end else if (row_pos < {32'd0, src_w} * 3 && src_row < {32'd0, src_h}) begin
                lastrow = src_h - 1;
                img = top_down ? src_row : {32'd0, lastrow} - src_row;
                if (img >= org_r && img - org_r < win_h && p >= org_c && p - org_c < win_w)
                begin
                    orow = img - org_r;
                    ocol = p - org_c;
                    fin = (ocol == {32'd0, win_w - 32'd1}) &&
                          (orow == (top_down ? {32'd0, win_h - 32'd1} : 64'd0));
                    px.kind = fin ? KIND_LAST : KIND_PIXEL;
                    px.color = {b[7:3], part_px[15:10], part_px[7:3]};
                    px.col = ocol[9:0];
                    px.row = orow[9:0];
                    px.iw = win_w[10:0];
                    px.ih = win_h[10:0];
                    got = 1'b1;
                    if (fin) dec_state = ST_DRAIN;
                end
            end
            row_pos = row_pos + 1;
            if (row_pos >= row_len) begin
                row_pos = '0;
                src_row = src_row + 1;
            end
        end
        if (dec_state == ST_SKIP && dec_cnt >= hdr[2]) dec_state = ST_PIXELS;
        if (dec_cnt >= file_len) clear_file();
        return got;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Registers only change with the decoder idle: nothing owed and the
    // header check pipeline given time to settle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DISP_W:   disp_w = v[10:0];
            CFG_DISP_H:   disp_h = v[10:0];
            CFG_FILE_LEN: file_len = v;
            default: ;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_px px;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        if (decode_byte(b, px) && !typed_err) pending_pixels.push_back(px);
    endtask

    function automatic void put32(input int at, input logic [31:0] v);
        for (int i = 0; i < 4; i++) hb[at + i] = v[8 * i +: 8];
    endfunction

    // Builds a file: header, random gap and pixel bytes, random tail.
    function automatic logic [31:0] build_file(input int unsigned w, input int unsigned h,
                                               input bit td, input file_case_e fc);
        logic [31:0] dib, poff, rowl, fend, flen, declared, hs, wsf;
        int          nb, at;
        file_bytes.delete();
        if (fc == FC_SHORT) begin
            // length below one header; a zero length faults on every byte
            nb = (w == 0) ? 3 : w;
            repeat (nb) file_bytes.push_back(8'($urandom));
            return w;
        end
        dib = 40 + $urandom_range(0, 8);
        poff = 14 + dib + $urandom_range(0, 3);
        rowl = (w * 3 + 3) & ~32'd3;
        fend = poff + rowl * h;
        flen = fend + $urandom_range(0, 3);
        declared = fend + $urandom_range(0, flen - fend);
        hs = td ? 32'd0 - h : h;
        wsf = w;
        foreach (hb[i]) hb[i] = 8'($urandom);
        hb[0] = "B";
        hb[1] = "M";
        hb[26] = 8'd1;
        hb[27] = 8'd0;
        hb[28] = 8'd24;
        hb[29] = 8'd0;
        put32(30, 32'd0);
        case (fc)
            FC_BAD_SIG:    hb[1] = "N";
            FC_BAD_DEPTH:  hb[28] = 8'd16;
            FC_COMPRESSED: put32(30, $urandom_range(1, 3));
            FC_HEIGHT_MIN: hs = 32'h8000_0000;
            FC_WIDTH_NEG:  wsf = 32'h8000_0000 | w;
            FC_TRUNCATED:  declared = fend - 1;
            FC_OFFSET_LOW: poff = 13 + dib;
            FC_DIB_SMALL:  dib = 39;
            default: ;
        endcase
        put32(2, declared);
        put32(10, poff);
        put32(14, dib);
        put32(18, wsf);
        put32(22, hs);
        if (fc == FC_BITFLIP) begin
            at = $urandom_range(0, 33);
            hb[at][$urandom_range(0, 7)] ^= 1'b1;
        end
        foreach (hb[i]) file_bytes.push_back(hb[i]);
        repeat (flen - 54) file_bytes.push_back(8'($urandom));
        return flen;
    endfunction

    task automatic run_file(input t_file_spec fr, input bit counted);
        logic [31:0] flen;
        t_px         err_px;
        flen = build_file(fr.w, fr.h, fr.td, fr.fcase);
        write_reg(CFG_DISP_W, fr.dw);
        write_reg(CFG_DISP_H, fr.dh);
        write_reg(CFG_FILE_LEN, flen);
        // idle pattern rotates per file so gaps land on every decoder phase
        case (file_no % 5)
            1: begin gap_pct = 85; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 85; end
            3: begin gap_pct = 18; stall_pct = 18; end
            default: begin gap_pct = 0; stall_pct = 0; end
        endcase
        file_no++;
        // Faulty files and zero display sizes: the error result is known
        typed_err = (fr.fcase != FC_OK && fr.fcase != FC_BITFLIP) ||
                    fr.dw[10:0] == 0 || fr.dh[10:0] == 0;
        if (typed_err) begin
            err_px = '{kind: KIND_ERROR, default: '0};
            repeat ((fr.fcase == FC_SHORT && flen == 0) ? file_bytes.size() : 1)
                pending_pixels.push_back(err_px);
        end
        foreach (file_bytes[i]) send_byte(file_bytes[i]);
        if (counted) rnd_bytes += file_bytes.size();
        typed_err = 1'b0;
    endtask

    // Directed files: faults, crop shapes, both row orders and the clip limits
    t_file_spec dir_files [17] = '{
        '{320, 240, 53, 0, 0, FC_SHORT},
        '{320, 240, 0, 0, 0, FC_SHORT},
        '{320, 240, 4, 3, 0, FC_OK},
        '{320, 240, 5, 2, 1, FC_OK},
        '{2, 2, 7, 3, 0, FC_OK},
        '{3, 1, 6, 2, 1, FC_OK},
        '{0, 240, 2, 2, 0, FC_OK},
        '{5, 0, 2, 2, 1, FC_OK},
        '{320, 240, 1, 1, 0, FC_BAD_SIG},
        '{320, 240, 1, 1, 0, FC_BAD_DEPTH},
        '{320, 240, 1, 1, 0, FC_COMPRESSED},
        '{320, 240, 1, 1, 0, FC_HEIGHT_MIN},
        '{320, 240, 1, 1, 0, FC_WIDTH_NEG},
        '{320, 240, 1, 1, 0, FC_TRUNCATED},
        '{320, 240, 1, 1, 0, FC_OFFSET_LOW},
        '{320, 240, 1, 1, 0, FC_DIB_SMALL},
        '{1024, 2047, 2, 1, 0, FC_OK}
    };

    initial begin
        t_file_spec fr;
        int         pick;
        disp_w = 11'd320;
        disp_h = 11'd240;
        file_len = '0;
        clear_file();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // largest file length, overwritten by the first file
        write_reg(CFG_FILE_LEN, 32'hFFFF_FFFF);
        foreach (dir_files[i]) run_file(dir_files[i], 1'b0);

        // Random files: mostly well formed with random content and crop
        while (rnd_bytes < RANDOM_BYTES) begin
            fr.dw = ($urandom_range(9) == 0) ? 2047 : $urandom_range(1, 8);
            fr.dh = ($urandom_range(9) == 0) ? 1024 : $urandom_range(1, 4);
            fr.w = $urandom_range(1, 8);
            fr.h = $urandom_range(1, 4);
            fr.td = $urandom_range(1);
            pick = $urandom_range(99);
            if (pick < 70) begin
                fr.fcase = FC_OK;
            end else if (pick < 85) begin
                fr.fcase = FC_BITFLIP;
            end else if (pick < 90) begin
                fr.fcase = FC_SHORT;
                fr.w = $urandom_range(0, 53);
            end else begin
                fr.fcase = file_case_e'($urandom_range(FC_BAD_SIG, FC_DIB_SMALL));
            end
            run_file(fr, 1'b1);
        end
        i_in_valid <= 1'b0;

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure and in-order comparison
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_px want, got;
        i_out_ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_kind, o_pixel_color, o_out_column, o_out_row,
                    o_image_width, o_image_height};
            if (pending_pixels.size() == 0) begin
                n_mismatch++;
                $display("%0t: unexpected result kind=%0d colour=%h col=%0d row=%0d",
                         $time, got.kind, got.color, got.col, got.row);
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    $display("%0t: expected kind=%0d colour=%h col=%0d row=%0d w=%0d h=%0d",
                             $time, want.kind, want.color, want.col, want.row,
                             want.iw, want.ih);
                    $display("%0t: actual   kind=%0d colour=%h col=%0d row=%0d w=%0d h=%0d",
                             $time, got.kind, got.color, got.col, got.row,
                             got.iw, got.ih);
                end
            end
        end
    end

    // Watchdog: any transfer on any channel restarts the count
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

@@ bmp24_crop_to_rgb565_unit.f @@
design/bmpc_pkg.sv
design/bmpc_front.sv
design/bmpc_hdr.sv
design/bmpc_back.sv
design/bmp24_crop_to_rgb565_unit.sv
verif/bmp24_crop_to_rgb565_unit_test.sv
